[rtl/core/fsd_pkg.sv]
// Shared types, register indexes and reset values for the byte-stuffed frame decoder.
package fsd_pkg;

	localparam int BYTE_W      = 8;
	localparam int ENTRY_W     = 25;
	localparam int CFG_IDX_W   = 3;
	localparam int MAX_ENTRIES = 3;

	// Default number of escape table entries
	localparam int ESCAPE_ENTRIES_DEF = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_BYTE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_BYTE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RETURN_GARBAGE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_ENTRY0  = 3'd3;

	// Register reset values
	localparam logic [BYTE_W-1:0]  OPEN_BYTE_RST      = 8'd2;
	localparam logic [BYTE_W-1:0]  CLOSE_BYTE_RST     = 8'd3;
	localparam logic               RETURN_GARBAGE_RST = 1'b1;
	localparam logic [ENTRY_W-1:0] ESCAPE_ENTRY_RST   = '0;

	// Escape entry field positions
	localparam int ENT_VALID_BIT = 24;
	localparam int ENT_PLAIN_LSB = 16;
	localparam int ENT_FIRST_LSB = 8;
	localparam int ENT_SECOND_LSB = 0;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_GARBAGE  = 2'd1,
		KIND_COMPLETE = 2'd2,
		KIND_ABORT    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		kind_t             kind;
		logic              last;
	} result_t;

	typedef struct packed {
		logic              in_frame;
		logic              holding;
		logic [BYTE_W-1:0] held_byte;
	} dec_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] open_byte;
		logic [BYTE_W-1:0] close_byte;
		logic              return_garbage;
	} dec_cfg_t;

endpackage

[rtl/core/fsd_decode.sv]
// One-byte decode step: markers, escape pair lookup and next deframer state.
module fsd_decode #(
	parameter int ESCAPE_ENTRIES = fsd_pkg::ESCAPE_ENTRIES_DEF
) (
	input  logic [fsd_pkg::BYTE_W-1:0]  rx_byte,
	input  fsd_pkg::dec_state_t         cur,
	input  fsd_pkg::dec_cfg_t           cfg,
	input  logic [fsd_pkg::ENTRY_W-1:0] entry [ESCAPE_ENTRIES],
	output fsd_pkg::dec_state_t         nxt,
	output logic [1:0]                  res_cnt,
	output fsd_pkg::result_t            res0,
	output fsd_pkg::result_t            res1
);

	logic                      pair_hit;
	logic [fsd_pkg::BYTE_W-1:0] pair_plain;
	logic                      first_hit;

	// Look up the held pair; lowest valid entry wins
	always_comb begin
		pair_hit   = 1'b0;
		pair_plain = '0;
		first_hit  = 1'b0;
		for (int i = ESCAPE_ENTRIES - 1; i >= 0; i--) begin
			if (entry[i][fsd_pkg::ENT_VALID_BIT] &&
			    entry[i][fsd_pkg::ENT_FIRST_LSB +: fsd_pkg::BYTE_W] == cur.held_byte &&
			    entry[i][fsd_pkg::ENT_SECOND_LSB +: fsd_pkg::BYTE_W] == rx_byte) begin
				pair_hit   = 1'b1;
				pair_plain = entry[i][fsd_pkg::ENT_PLAIN_LSB +: fsd_pkg::BYTE_W];
			end
			if (entry[i][fsd_pkg::ENT_VALID_BIT] &&
			    entry[i][fsd_pkg::ENT_FIRST_LSB +: fsd_pkg::BYTE_W] == rx_byte) begin
				first_hit = 1'b1;
			end
		end
	end

	// Build up to two results and the next state
	always_comb begin
		fsd_pkg::result_t fresh;
		logic             fresh_ok;

		nxt      = cur;
		res_cnt  = 2'd0;
		res0     = '0;
		res1     = '0;
		fresh    = '0;
		fresh_ok = 1'b0;

		// Handle the byte as a fresh byte inside a frame
		if (rx_byte == cfg.close_byte) begin
			fresh    = '{data: '0, kind: fsd_pkg::KIND_COMPLETE, last: 1'b1};
			fresh_ok = 1'b1;
		end else if (rx_byte == cfg.open_byte) begin
			fresh    = '{data: '0, kind: fsd_pkg::KIND_ABORT, last: 1'b1};
			fresh_ok = 1'b1;
		end else if (!first_hit) begin
			fresh    = '{data: rx_byte, kind: fsd_pkg::KIND_DATA, last: 1'b1};
			fresh_ok = 1'b1;
		end

		if (!cur.in_frame) begin
			if (rx_byte == cfg.open_byte) begin
				nxt.in_frame = 1'b1;
				nxt.holding  = 1'b0;
			end else if (cfg.return_garbage) begin
				res0    = '{data: rx_byte, kind: fsd_pkg::KIND_GARBAGE, last: 1'b1};
				res_cnt = 2'd1;
			end
		end else if (cur.holding && pair_hit) begin
			// Matched escape pair decodes to its plain byte
			nxt.holding = 1'b0;
			res0        = '{data: pair_plain, kind: fsd_pkg::KIND_DATA, last: 1'b1};
			res_cnt     = 2'd1;
		end else begin
			nxt.holding = 1'b0;
			if (rx_byte == cfg.close_byte) begin
				nxt.in_frame = 1'b0;
			end else if (rx_byte != cfg.open_byte && first_hit) begin
				nxt.holding   = 1'b1;
				nxt.held_byte = rx_byte;
			end
			if (cur.holding) begin
				// Unmatched pair: release the held byte first
				res0    = '{data: cur.held_byte, kind: fsd_pkg::KIND_DATA, last: !fresh_ok};
				res1    = fresh;
				res_cnt = fresh_ok ? 2'd2 : 2'd1;
			end else begin
				res0    = fresh;
				res_cnt = fresh_ok ? 2'd1 : 2'd0;
			end
		end
	end

endmodule

[rtl/core/byte_stuffed_frame_decoder_unit.sv]
// Byte-stuffed frame decoder top level: input stage, decode state, result queue, registers.
//
// Accepts one received byte per clock cycle and streams out decoded frame bytes,
// garbage bytes and frame complete/aborted events, one result per cycle on the
// output channel while out_ready is high. A byte is registered on input and
// decoded in the next cycle, which can yield zero, one or two results; these go
// into a four-entry result queue, and the input stage advances only while the
// queue has room for two. Sustained rate is one byte per cycle while each byte
// yields at most one result; a byte that yields two results (a released escape
// byte plus its follower) costs the output an extra result transfer. Results
// are written into the queue when the input stage advances, and the output shows
// the queue head. The configuration port is always ready and should be written
// only while the block is idle.
module byte_stuffed_frame_decoder_unit #(
	parameter int ESCAPE_ENTRIES = fsd_pkg::ESCAPE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsd_pkg::ENTRY_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fsd_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fsd_pkg::BYTE_W-1:0]    out_byte,
	output logic [1:0]                    kind,
	output logic                          last
);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	fsd_pkg::dec_cfg_t          cfg_q;
	logic [fsd_pkg::ENTRY_W-1:0] entry_q [ESCAPE_ENTRIES];
	fsd_pkg::dec_state_t        state_q;
	fsd_pkg::dec_state_t        state_nxt;

	logic                       valid_s1;
	logic [fsd_pkg::BYTE_W-1:0] byte_s1;
	logic                       go;

	logic [1:0]                 res_cnt;
	fsd_pkg::result_t           res0;
	fsd_pkg::result_t           res1;

	fsd_pkg::result_t           queue_q [QDEPTH];
	logic [QPTR_W-1:0]          wr_ptr_q;
	logic [QPTR_W-1:0]          rd_ptr_q;
	logic [QCNT_W-1:0]          count_q;
	logic                       pop;
	logic [QCNT_W-1:0]          push_n;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_byte      <= fsd_pkg::OPEN_BYTE_RST;
			cfg_q.close_byte     <= fsd_pkg::CLOSE_BYTE_RST;
			cfg_q.return_garbage <= fsd_pkg::RETURN_GARBAGE_RST;
			for (int i = 0; i < ESCAPE_ENTRIES; i++) begin
				entry_q[i] <= fsd_pkg::ESCAPE_ENTRY_RST;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == fsd_pkg::REG_OPEN_BYTE) begin
				cfg_q.open_byte <= cfg_data[fsd_pkg::BYTE_W-1:0];
			end
			if (cfg_index == fsd_pkg::REG_CLOSE_BYTE) begin
				cfg_q.close_byte <= cfg_data[fsd_pkg::BYTE_W-1:0];
			end
			if (cfg_index == fsd_pkg::REG_RETURN_GARBAGE) begin
				cfg_q.return_garbage <= cfg_data[0];
			end
			for (int i = 0; i < ESCAPE_ENTRIES; i++) begin
				if (cfg_index == fsd_pkg::REG_ESCAPE_ENTRY0 + fsd_pkg::CFG_IDX_W'(i)) begin
					entry_q[i] <= cfg_data;
				end
			end
		end
	end

	// Input stage: advance when the queue can take two results
	assign go       = valid_s1 && (count_q <= QCNT_W'(QDEPTH - 2));
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	fsd_decode #(
		.ESCAPE_ENTRIES(ESCAPE_ENTRIES)
	) u_decode (
		.rx_byte (byte_s1),
		.cur     (state_q),
		.cfg     (cfg_q),
		.entry   (entry_q),
		.nxt     (state_nxt),
		.res_cnt (res_cnt),
		.res0    (res0),
		.res1    (res1)
	);

	// Deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (go) begin
			state_q <= state_nxt;
		end
	end

	// Result queue
	assign pop    = out_valid && out_ready;
	assign push_n = go ? QCNT_W'(res_cnt) : '0;

	always_ff @(posedge clk) begin
		if (go && res_cnt != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (go && res_cnt == 2'd2) begin
			queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + push_n - QCNT_W'(pop);
		end
	end

	// Drive the head result
	assign out_valid = (count_q != '0);
	assign out_byte  = queue_q[rd_ptr_q].data;
	assign kind      = queue_q[rd_ptr_q].kind;
	assign last      = queue_q[rd_ptr_q].last;

endmodule

[rtl/core/fsd_check.sv]
// Port-level checker for the byte-stuffed frame decoder, bound to the top level.
module fsd_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [fsd_pkg::BYTE_W-1:0]    out_byte,
	input logic [1:0]                    kind,
	input logic                          last
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
			&& $stable(last))
		else $error("stalled result changed");

	// End events carry a zero byte
	a_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == fsd_pkg::KIND_COMPLETE || kind == fsd_pkg::KIND_ABORT)
			|-> out_byte == '0)
		else $error("end event with nonzero byte");

	// End events and garbage always close their input byte
	a_event_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == fsd_pkg::KIND_COMPLETE || kind == fsd_pkg::KIND_ABORT
			|| kind == fsd_pkg::KIND_GARBAGE) |-> last)
		else $error("end event or garbage not marked last");

	// The second result of a byte follows without a gap
	a_pair_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("second result of a byte missing");

endmodule

bind byte_stuffed_frame_decoder_unit fsd_check u_fsd_check (.*);

[tb/sv/fsd_result_checker.sv]
// Result checker for the byte-stuffed frame decoder: tracks decoder state and compares outputs.
module fsd_result_checker
	import fsd_pkg::*;
#(
	parameter int ENTRIES = ESCAPE_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ENTRY_W-1:0]   cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [BYTE_W-1:0]    out_byte,
	input  logic [1:0]           kind,
	input  logic                 last,
	output int                   mismatches,
	output int                   results_owed
);

	// Register copies
	logic [BYTE_W-1:0]  open_mk;
	logic [BYTE_W-1:0]  close_mk;
	logic               keep_garbage;
	logic [ENTRY_W-1:0] esc_tab [MAX_ENTRIES];

	// Decoder state copy
	logic              framing;
	logic              holding;
	logic [BYTE_W-1:0] held;

	result_t pending_results [$];
	result_t want;

	// Print one line per mismatch and count it
	task automatic flag_mismatch(input string what, input logic [BYTE_W-1:0] got,
			input logic [BYTE_W-1:0] exp_val);
		$display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
		mismatches++;
	endtask

	function automatic result_t mk_result(input logic [BYTE_W-1:0] v, input kind_t k);
		result_t r;
		r.data = v;
		r.kind = k;
		r.last = 1'b0;
		return r;
	endfunction

	// True if some active, valid entry starts with byte a
	function automatic logic opens_pair(input logic [BYTE_W-1:0] a);
		for (int i = 0; i < ENTRIES && i < MAX_ENTRIES; i++) begin
			if (esc_tab[i][ENT_VALID_BIT] && esc_tab[i][ENT_FIRST_LSB +: BYTE_W] == a) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Lowest-numbered valid entry matching (a, b) gives the plain byte
	function automatic logic pair_lookup(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
			output logic [BYTE_W-1:0] plain);
		plain = '0;
		for (int i = 0; i < ENTRIES && i < MAX_ENTRIES; i++) begin
			if (esc_tab[i][ENT_VALID_BIT] && esc_tab[i][ENT_FIRST_LSB +: BYTE_W] == a
					&& esc_tab[i][ENT_SECOND_LSB +: BYTE_W] == b) begin
				plain = esc_tab[i][ENT_PLAIN_LSB +: BYTE_W];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Apply one register write; unknown indexes are dropped
	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [ENTRY_W-1:0] value);
		case (idx)
			REG_OPEN_BYTE:      open_mk = value[BYTE_W-1:0];
			REG_CLOSE_BYTE:     close_mk = value[BYTE_W-1:0];
			REG_RETURN_GARBAGE: keep_garbage = value[0];
			default: begin
				if (idx >= REG_ESCAPE_ENTRY0 && idx - REG_ESCAPE_ENTRY0 < MAX_ENTRIES) begin
					esc_tab[2'(idx - REG_ESCAPE_ENTRY0)] = value;
				end
			end
		endcase
	endtask

	// Advance the decoder state by one byte and queue the results it causes
	task automatic decode_rx_byte(input logic [BYTE_W-1:0] b);
		result_t burst [2];
		int n;
		logic [BYTE_W-1:0] plain;
		logic paired;
		n = 0;
		paired = 1'b0;
		plain = '0;
		burst[0] = '0;
		burst[1] = '0;
		if (!framing) begin
			if (b == open_mk) begin
				framing = 1'b1;
				holding = 1'b0;
			end else if (keep_garbage) begin
				burst[n] = mk_result(b, KIND_GARBAGE);
				n++;
			end
		end else begin
			// Resolve a held escape byte before looking at markers
			if (holding) begin
				holding = 1'b0;
				paired = pair_lookup(held, b, plain);
				burst[n] = mk_result(paired ? plain : held, KIND_DATA);
				n++;
			end
			if (!paired) begin
				if (b == close_mk) begin
					burst[n] = mk_result('0, KIND_COMPLETE);
					n++;
					framing = 1'b0;
				end else if (b == open_mk) begin
					burst[n] = mk_result('0, KIND_ABORT);
					n++;
				end else if (opens_pair(b)) begin
					holding = 1'b1;
					held = b;
				end else begin
					burst[n] = mk_result(b, KIND_DATA);
					n++;
				end
			end
		end
		if (n != 0) begin
			burst[n - 1].last = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			pending_results.insert(pending_results.size(), burst[i]);
		end
	endtask

	// Watch all three channels on each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_mk = OPEN_BYTE_RST;
			close_mk = CLOSE_BYTE_RST;
			keep_garbage = RETURN_GARBAGE_RST;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				esc_tab[i] = ESCAPE_ENTRY_RST;
			end
			framing = 1'b0;
			holding = 1'b0;
			held = '0;
			pending_results.delete();
			results_owed = 0;
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				apply_write(cfg_index, cfg_data);
			end
			// Compare an output transfer against the oldest expected result
			if (out_valid === 1'b1 && out_ready) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("result with none expected, out_byte", out_byte, '0);
				end else begin
					want = pending_results.pop_front();
					if (out_byte !== want.data) begin
						flag_mismatch("out_byte", out_byte, want.data);
					end
					if (kind !== want.kind) begin
						flag_mismatch("kind", BYTE_W'(kind), BYTE_W'(want.kind));
					end
					if (last !== want.last) begin
						flag_mismatch("last", BYTE_W'(last), BYTE_W'(want.last));
					end
				end
			end
			if (in_valid && in_ready === 1'b1) begin
				decode_rx_byte(rx_byte);
			end
			results_owed = pending_results.size();
		end
	end

endmodule

[tb/sv/tb_byte_stuffed_frame_decoder_unit.sv]
// Testbench top for the byte-stuffed frame decoder: stimulus, flow control and verdict.
module tb_byte_stuffed_frame_decoder_unit;
	import fsd_pkg::*;

	localparam int PHASES       = 8;
	localparam int PHASE_BYTES  = 150;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int SQUEEZE_CYC  = 300;
	localparam int SETTLE_CYC   = 8;

	// Indexes that hold no register
	localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = CFG_IDX_W'(REG_ESCAPE_ENTRY0 + MAX_ENTRIES);
	localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = '1;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ENTRY_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [BYTE_W-1:0]    out_byte;
	logic [1:0]           kind;
	logic                 last;

	int mismatches;
	int results_owed;

	// Stimulus-side view of the current markers and table
	logic [BYTE_W-1:0]  open_now;
	logic [BYTE_W-1:0]  close_now;
	logic [ENTRY_W-1:0] tab_now [MAX_ENTRIES];

	int unsigned bytes_sent = 0;
	int          burst_left = 0;
	bit          squeeze_req = 1'b0;

	byte_stuffed_frame_decoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.kind      (kind),
		.last      (last)
	);

	fsd_result_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.kind         (kind),
		.last         (last),
		.mismatches   (mismatches),
		.results_owed (results_owed)
	);

	// Clock: 12 units per period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Hard stop for a hung run
	initial begin
		#(12 * 400_000);
		$display("** byte_stuffed_frame_decoder_unit: FAILED **");
		$finish;
	end

	function automatic logic [ENTRY_W-1:0] pack_entry(input logic valid, input logic [7:0] plain,
			input logic [7:0] first, input logic [7:0] second);
		return {valid, plain, first, second};
	endfunction

	// One register write transfer, then drop valid
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ENTRY_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one byte, opening a new burst after a random gap when the old one runs out
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_list(input logic [BYTE_W-1:0] seq [$]);
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	// Drain all owed results, then give the pipeline time to go quiet
	task automatic settle();
		int waited;
		in_valid <= 1'b0;
		burst_left = 0;
		waited = 0;
		@(negedge clk);
		while (results_owed != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (results_owed != 0) begin
			$display("** byte_stuffed_frame_decoder_unit: FAILED **");
			$finish;
		end else begin
			repeat (SETTLE_CYC) @(posedge clk);
		end
	endtask

	// Program markers and table for one random phase; first and last phases use extremes
	task automatic random_setup(input int ph);
		logic [BYTE_W-1:0]  shared_first;
		logic [ENTRY_W-1:0] ent;
		if (ph == 0) begin
			open_now = 8'h00;
			close_now = 8'hFF;
		end else if (ph == PHASES - 1) begin
			open_now = 8'hFF;
			close_now = 8'h00;
		end else begin
			open_now = 8'($urandom);
			close_now = ($urandom_range(0, 7) == 0) ? open_now : 8'($urandom);
		end
		// Junk above the marker width must be dropped
		write_reg(REG_OPEN_BYTE, {17'($urandom), open_now});
		write_reg(REG_CLOSE_BYTE, {17'($urandom), close_now});
		write_reg(REG_RETURN_GARBAGE, ENTRY_W'($urandom));
		shared_first = 8'($urandom);
		for (int k = 0; k < MAX_ENTRIES; k++) begin
			if (ph == 0) begin
				ent = pack_entry(1'b1, 8'(k), 8'h01, 8'h00);
			end else if (ph == PHASES - 1) begin
				ent = '1;
			end else begin
				ent = ENTRY_W'($urandom);
				ent[ENT_VALID_BIT] = ($urandom_range(0, 7) != 0);
				if ($urandom_range(0, 1) == 0) ent[ENT_FIRST_LSB +: BYTE_W] = shared_first;
			end
			tab_now[k] = ent;
			write_reg(CFG_IDX_W'(REG_ESCAPE_ENTRY0 + k), ent);
		end
		if ($urandom_range(0, 2) == 0) write_reg(REG_NONE_HI, ENTRY_W'($urandom));
	endtask

	// Mostly well-formed frames with random content, the rest line noise
	task automatic run_traffic(input int unsigned target);
		int len;
		logic [ENTRY_W-1:0] ent;
		logic [BYTE_W-1:0] first;
		while (bytes_sent < target) begin
			if ($urandom_range(0, 9) < 7) begin
				send_byte(open_now);
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
				repeat (len) begin
					ent = tab_now[2'($urandom_range(0, MAX_ENTRIES - 1))];
					first = ent[ENT_FIRST_LSB +: BYTE_W];
					case ($urandom_range(0, 9))
						0, 1, 2, 3: send_byte(8'($urandom));
						4, 5, 6: begin
							send_byte(first);
							send_byte(ent[ENT_SECOND_LSB +: BYTE_W]);
						end
						7: begin
							send_byte(first);
							send_byte(8'($urandom));
						end
						8: send_byte(open_now);
						default: send_byte(first);
					endcase
				end
				if ($urandom_range(0, 9) != 0) send_byte(close_now);
			end else begin
				send_byte(8'($urandom));
			end
		end
	endtask

	// Receiver: picks a new random stall pattern when the current one runs out; one long hold-off on request
	initial begin : receiver
		int stall_mode;
		int mode_left;
		stall_mode = 0;
		mode_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				out_ready <= 1'b0;
				repeat (SQUEEZE_CYC) @(posedge clk);
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(8, 80);
			end
			mode_left--;
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 7) != 0);
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		logic [BYTE_W-1:0] seq [$];
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rx_byte <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: open, data, close
		seq = '{8'h02, 8'hFF, 8'h03};
		send_list(seq);
		settle();

		// Garbage dropped, escapes live, duplicate pair in entry two, bogus indexes
		write_reg(REG_OPEN_BYTE, 25'h7E);
		write_reg(REG_CLOSE_BYTE, 25'h7F);
		write_reg(REG_RETURN_GARBAGE, 25'h0);
		write_reg(REG_ESCAPE_ENTRY0, pack_entry(1'b1, 8'h7E, 8'h7D, 8'h5E));
		write_reg(CFG_IDX_W'(REG_ESCAPE_ENTRY0 + 1), pack_entry(1'b1, 8'h11, 8'h7D, 8'h7F));
		write_reg(CFG_IDX_W'(REG_ESCAPE_ENTRY0 + 2), pack_entry(1'b1, 8'hAA, 8'h7D, 8'h5E));
		write_reg(REG_NONE_LO, '1);
		write_reg(REG_NONE_HI, '1);
		// pair, pair ending in stop byte, unmatched pair, held twice, held then abort,
		// pair after abort, close, dropped garbage
		seq = '{8'h55, 8'h7E, 8'h7D, 8'h5E, 8'h7D, 8'h7F, 8'h7D, 8'h41, 8'h7D, 8'h7D,
			8'h5E, 8'h7D, 8'h7E, 8'h7D, 8'h7F, 8'h7F, 8'h7D};
		send_list(seq);
		settle();

		// Equal markers, invalid entry, marker as first escape byte, pair ending in marker
		write_reg(REG_OPEN_BYTE, 25'h0);
		write_reg(REG_CLOSE_BYTE, 25'h0);
		write_reg(REG_RETURN_GARBAGE, 25'h1);
		write_reg(REG_ESCAPE_ENTRY0, pack_entry(1'b0, 8'h33, 8'hFF, 8'hFF));
		write_reg(CFG_IDX_W'(REG_ESCAPE_ENTRY0 + 1), pack_entry(1'b1, 8'h44, 8'h00, 8'h01));
		write_reg(CFG_IDX_W'(REG_ESCAPE_ENTRY0 + 2), pack_entry(1'b1, 8'h55, 8'hFF, 8'h00));
		seq = '{8'h99, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00};
		send_list(seq);
		settle();

		// Random phases, one with a long receiver hold-off
		for (int ph = 0; ph < PHASES; ph++) begin
			random_setup(ph);
			if (ph == 2) squeeze_req = 1'b1;
			run_traffic(bytes_sent + PHASE_BYTES);
			settle();
		end

		if (mismatches == 0) begin
			$display("** byte_stuffed_frame_decoder_unit: PASSED **");
		end else begin
			$display("** byte_stuffed_frame_decoder_unit: FAILED **");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/fsd_pkg.sv
rtl/core/fsd_decode.sv
rtl/core/byte_stuffed_frame_decoder_unit.sv
rtl/core/fsd_check.sv
tb/sv/fsd_result_checker.sv
tb/sv/tb_byte_stuffed_frame_decoder_unit.sv
